// File: hw/rtl/stpg_pkg.sv
// Shared types, constants and angle table for the scan-to-grid pipeline.
`default_nettype none

package stpg_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int XW = 36;
	localparam int ZW = 18;
	localparam int RW = 30;
	localparam int QW = 12;
	localparam int SCALE_SHIFT = 17;
	localparam int MAX_IMAGE = 1024;
	localparam int MAX_BEAMS = 4096;

	localparam logic [15:0] INV_GAIN = 16'd39797;
	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(16384);
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(32768);
	localparam logic [10:0] SIZE_LIMIT = 11'(MAX_IMAGE);

	localparam logic [2:0] REG_START_ANGLE = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd1;
	localparam logic [2:0] REG_ROTATION_OFFSET = 3'd2;
	localparam logic [2:0] REG_MIN_RANGE = 3'd3;
	localparam logic [2:0] REG_MAX_RANGE = 3'd4;
	localparam logic [2:0] REG_IMAGE_SIZE = 3'd5;

	localparam logic signed [ZW-1:0] ATAN [CORDIC_STEPS] = '{
		ZW'(8192), ZW'(4836), ZW'(2555), ZW'(1297), ZW'(651), ZW'(326), ZW'(163), ZW'(81),
		ZW'(41), ZW'(20), ZW'(10), ZW'(5), ZW'(3), ZW'(1), ZW'(1), ZW'(0)
	};

	typedef struct packed {
		logic [15:0] range_sample;
		logic [11:0] beam_index;
	} in_t;

	typedef struct packed {
		logic       hit;
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
	} out_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 ok;
	} cordic_t;

	typedef struct packed {
		logic [RW-1:0] rem_x;
		logic [RW-1:0] rem_y;
		logic [QW-1:0] q_x;
		logic [QW-1:0] q_y;
		logic          neg_x;
		logic          neg_y;
		logic          ok;
	} div_t;

endpackage

`default_nettype wire

// File: hw/rtl/stpg_front.sv
// Front stages: beam angle, range check, gain prescale and half-turn pre-rotation.
`default_nettype none

module stpg_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire stpg_pkg::in_t    in_data,
	output logic                  take,
	input  wire logic [15:0]      start_angle,
	input  wire logic [15:0]      angle_step,
	input  wire logic [15:0]      rotation_offset,
	input  wire logic [15:0]      min_range,
	input  wire logic [15:0]      range_limit,
	output logic                  valid,
	output stpg_pkg::cordic_t     data,
	input  wire logic             take_next
);
	import stpg_pkg::*;

	logic               valid_s1;
	logic [15:0]        angle_s1;
	logic [31:0]        x0_s1;
	logic               ok_s1;
	logic               valid_s2;
	cordic_t            data_s2;
	logic               take_s1;
	logic               take_s2;
	logic [27:0]        prod;
	logic [15:0]        angle;
	logic signed [ZW-1:0] z_in;
	logic signed [XW-1:0] x_pos;
	logic               flip;
	cordic_t            pre;

	assign take_s2 = !valid_s2 || take_next;
	assign take_s1 = !valid_s1 || take_s2;
	assign take = take_s1;

	assign prod = 28'(in_data.beam_index) * 28'(angle_step);
	assign angle = start_angle + prod[15:0] + rotation_offset;

	always_comb begin
		z_in = {{(ZW-16){angle_s1[15]}}, angle_s1};
		x_pos = {{(XW-32){1'b0}}, x0_s1};
		flip = (z_in > Z_QUARTER) || (z_in < -Z_QUARTER);
		pre.ok = ok_s1;
		pre.y = '0;
		if (flip) begin
			pre.x = -x_pos;
			pre.z = (z_in > 0) ? z_in - Z_HALF : z_in + Z_HALF;
		end else begin
			pre.x = x_pos;
			pre.z = z_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= in_valid;
			if (take_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			angle_s1 <= angle;
			x0_s1 <= 32'(in_data.range_sample) * 32'(INV_GAIN);
			ok_s1 <= (in_data.range_sample > min_range) &&
				(in_data.range_sample < range_limit);
		end
		if (take_s2) begin
			data_s2 <= pre;
		end
	end

	assign valid = valid_s2;
	assign data = data_s2;

endmodule

`default_nettype wire

// File: hw/rtl/stpg_cordic_cell.sv
// One CORDIC rotation cell with its own stage register.
`default_nettype none

module stpg_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire stpg_pkg::cordic_t in_data,
	output logic                   take,
	output logic                   valid,
	output stpg_pkg::cordic_t      data,
	input  wire logic              take_next
);
	import stpg_pkg::*;

	logic    valid_q;
	cordic_t data_q;
	cordic_t nxt;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign take = !valid_q || take_next;
	assign dx = in_data.y >>> STEP;
	assign dy = in_data.x >>> STEP;

	always_comb begin
		nxt.ok = in_data.ok;
		if (!in_data.z[ZW-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - ATAN[STEP];
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + ATAN[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) data_q <= nxt;
	end

	assign valid = valid_q;
	assign data = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/stpg_scale.sv
// Scale stage: magnitude times image size, ready for division by the range limit.
`default_nettype none

module stpg_scale (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire stpg_pkg::cordic_t in_data,
	output logic                   take,
	input  wire logic [10:0]       size,
	output logic                   valid,
	output stpg_pkg::div_t         data,
	input  wire logic              take_next
);
	import stpg_pkg::*;

	logic          valid_q;
	div_t          data_q;
	div_t          nxt;
	logic [XW-2:0] mag_x;
	logic [XW-2:0] mag_y;
	logic [XW+9:0] prod_x;
	logic [XW+9:0] prod_y;
	logic signed [XW-1:0] neg_x;
	logic signed [XW-1:0] neg_y;

	assign take = !valid_q || take_next;

	always_comb begin
		neg_x = -in_data.x;
		neg_y = -in_data.y;
		mag_x = in_data.x[XW-1] ? neg_x[XW-2:0] : in_data.x[XW-2:0];
		mag_y = in_data.y[XW-1] ? neg_y[XW-2:0] : in_data.y[XW-2:0];
		prod_x = (XW+10)'(mag_x) * (XW+10)'(size);
		prod_y = (XW+10)'(mag_y) * (XW+10)'(size);
		nxt.rem_x = RW'(prod_x >> SCALE_SHIFT);
		nxt.rem_y = RW'(prod_y >> SCALE_SHIFT);
		nxt.q_x = '0;
		nxt.q_y = '0;
		nxt.neg_x = in_data.x[XW-1];
		nxt.neg_y = in_data.y[XW-1];
		nxt.ok = in_data.ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) data_q <= nxt;
	end

	assign valid = valid_q;
	assign data = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/stpg_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both coordinates.
`default_nettype none

module stpg_div_cell #(
	parameter int BIT = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire stpg_pkg::div_t in_data,
	output logic                take,
	input  wire logic [15:0]    range_limit,
	output logic                valid,
	output stpg_pkg::div_t      data,
	input  wire logic           take_next
);
	import stpg_pkg::*;

	logic          valid_q;
	div_t          data_q;
	div_t          nxt;
	logic [RW-1:0] sub;

	assign take = !valid_q || take_next;
	assign sub = RW'(range_limit) << BIT;

	always_comb begin
		nxt = in_data;
		if (in_data.rem_x >= sub) begin
			nxt.rem_x = in_data.rem_x - sub;
			nxt.q_x[BIT] = 1'b1;
		end
		if (in_data.rem_y >= sub) begin
			nxt.rem_y = in_data.rem_y - sub;
			nxt.q_y[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) data_q <= nxt;
	end

	assign valid = valid_q;
	assign data = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/stpg_out.sv
// Output stage: sign, centre offset, bounds check and result register.
`default_nettype none

module stpg_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire stpg_pkg::div_t in_data,
	output logic                take,
	input  wire logic [10:0]    size,
	output logic                out_valid,
	output stpg_pkg::out_t      out_data,
	input  wire logic           out_stall
);
	import stpg_pkg::*;

	logic                 valid_q;
	out_t                 data_q;
	out_t                 nxt;
	logic [9:0]           half;
	logic signed [QW+1:0] qx;
	logic signed [QW+1:0] qy;
	logic signed [QW+1:0] px;
	logic signed [QW+1:0] py;
	logic signed [QW+1:0] lim;
	logic                 in_img;

	assign take = !valid_q || !out_stall;
	assign half = size[10:1];

	always_comb begin
		qx = signed'((QW+2)'(in_data.q_x));
		qy = signed'((QW+2)'(in_data.q_y));
		if (in_data.neg_x) qx = -qx;
		if (in_data.neg_y) qy = -qy;
		px = qx + signed'((QW+2)'(half));
		py = qy + signed'((QW+2)'(half));
		lim = signed'((QW+2)'(size));
		in_img = !px[QW+1] && !py[QW+1] && (px < lim) && (py < lim);
		nxt.hit = in_data.ok && in_img;
		nxt.pixel_x = nxt.hit ? px[9:0] : 10'd0;
		nxt.pixel_y = nxt.hit ? py[9:0] : 10'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/scan_points_to_grid.sv
// Top level: lidar range sample to grid pixel, configuration registers and cell chain.
// Stage registers from accepted input word to output word: 2 front, 16 CORDIC,
// 1 scale, 12 division, 1 output. Throughput: one word per cycle when the output
// is not stalled, set by the cell chain; each cell loads whenever it is empty or
// its neighbor moves, so bubbles close up while the output is stalled. Reset clears
// all valid bits and loads the configuration defaults; no clearing pass.
`default_nettype none

module scan_points_to_grid (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_addr,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire stpg_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output stpg_pkg::out_t      out_data
);
	import stpg_pkg::*;

	logic [15:0] start_angle_q;
	logic [15:0] angle_step_q;
	logic [15:0] rotation_offset_q;
	logic [15:0] min_range_q;
	logic [15:0] range_limit_q;
	logic [10:0] image_size_q;
	logic [10:0] size;

	logic              front_take;
	logic [CORDIC_STEPS:0] cd_valid;
	logic [CORDIC_STEPS:0] cd_take;
	cordic_t           cd_data [CORDIC_STEPS+1];
	logic [QW:0]       dv_valid;
	logic [QW:0]       dv_take;
	div_t              dv_data [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= 16'd0;
			angle_step_q <= 16'd0;
			rotation_offset_q <= 16'd0;
			min_range_q <= 16'd0;
			range_limit_q <= 16'hFFFF;
			image_size_q <= 11'd410;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_START_ANGLE: start_angle_q <= cfg_data;
				REG_ANGLE_STEP: angle_step_q <= cfg_data;
				REG_ROTATION_OFFSET: rotation_offset_q <= cfg_data;
				REG_MIN_RANGE: min_range_q <= cfg_data;
				REG_MAX_RANGE: range_limit_q <= cfg_data;
				REG_IMAGE_SIZE: image_size_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign size = (image_size_q > SIZE_LIMIT) ? SIZE_LIMIT : image_size_q;
	assign in_stall = !front_take;

	stpg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_data(in_data),
		.take(front_take),
		.start_angle(start_angle_q),
		.angle_step(angle_step_q),
		.rotation_offset(rotation_offset_q),
		.min_range(min_range_q),
		.range_limit(range_limit_q),
		.valid(cd_valid[0]),
		.data(cd_data[0]),
		.take_next(cd_take[0])
	);

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		stpg_cordic_cell #(.STEP(k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(cd_valid[k]),
			.in_data(cd_data[k]),
			.take(cd_take[k]),
			.valid(cd_valid[k+1]),
			.data(cd_data[k+1]),
			.take_next(cd_take[k+1])
		);
	end

	stpg_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cd_valid[CORDIC_STEPS]),
		.in_data(cd_data[CORDIC_STEPS]),
		.take(cd_take[CORDIC_STEPS]),
		.size(size),
		.valid(dv_valid[0]),
		.data(dv_data[0]),
		.take_next(dv_take[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_div
		stpg_div_cell #(.BIT(QW-1-k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(dv_valid[k]),
			.in_data(dv_data[k]),
			.take(dv_take[k]),
			.range_limit(range_limit_q),
			.valid(dv_valid[k+1]),
			.data(dv_data[k+1]),
			.take_next(dv_take[k+1])
		);
	end

	stpg_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(dv_valid[QW]),
		.in_data(dv_data[QW]),
		.take(dv_take[QW]),
		.size(size),
		.out_valid(out_valid),
		.out_data(out_data),
		.out_stall(out_stall)
	);

endmodule

`default_nettype wire
